### rtl/sliding_window_maximum_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window maximum block
// Clocked property checks used by the block's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/swm_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window maximum package
// Sizes, the candidate entry type, the per-cycle cell command and the
// control state encoding.
// ---------------------------------------------------------------------------
package swm_pkg;

  // Deque depth (largest window)
  localparam int K_MAX  = 64;
  localparam int DATA_W = 32;
  // Positions wrap modulo 2**POS_W, which exceeds any retained age
  localparam int POS_W  = 7;
  localparam int WIN_W  = 7;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] K_MAX_CNT = CNT_W'(K_MAX);
  localparam logic [WIN_W-1:0] K_MAX_WIN = WIN_W'(K_MAX);

  // One deque candidate
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                     clear;   // empty the deque
    logic                     shift;   // drop front, move all toward front
    logic                     insert;  // pop dominated tail, append sample
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

### rtl/swm_cell.sv
// ---------------------------------------------------------------------------
// Deque cell
// Holds one candidate; shifts from its back neighbor, drops itself when
// dominated by the new sample, and takes the sample when it is the first
// free slot.
// ---------------------------------------------------------------------------
module swm_cell (
  input  logic               clk,
  input  logic               rst,
  input  swm_pkg::cell_ctl_t ctl,
  input  swm_pkg::entry_t    right,
  input  logic               left_keep,
  output swm_pkg::entry_t    ent,
  output logic               keep
);

  // Candidate survives the new sample only if strictly greater
  assign keep = ent.valid && (ent.value > ctl.value);

  // Candidate register
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.clear) begin
      ent.valid <= 1'b0;
    end else if (ctl.shift) begin
      ent <= right;
    end else if (ctl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          ent.valid <= 1'b1;
          ent.value <= ctl.value;
          ent.pos   <= ctl.pos;
        end else begin
          ent.valid <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/swm_chain.sv
// ---------------------------------------------------------------------------
// Deque cell chain
// A row of candidate cells; cell 0 is the deque front. Each cell hands its
// entry to the front neighbor on a shift and its keep flag to the back one.
// ---------------------------------------------------------------------------
module swm_chain (
  input  logic               clk,
  input  logic               rst,
  input  swm_pkg::cell_ctl_t ctl,
  output swm_pkg::entry_t    front
);

  swm_pkg::entry_t links [swm_pkg::K_MAX+1];
  logic            keeps [swm_pkg::K_MAX];

  // Nothing shifts in behind the last cell
  assign links[swm_pkg::K_MAX] = '0;
  assign front                 = links[0];

  for (genvar i = 0; i < swm_pkg::K_MAX; i++) begin : g_cell
    logic left_keep;

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_keep = keeps[i-1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .right     (links[i+1]),
      .left_keep (left_keep),
      .ent       (links[i]),
      .keep      (keeps[i])
    );
  end

endmodule

### rtl/sliding_window_maximum.sv
// Flow: a sample is accepted in IDLE; in RUN the cell chain then shifts out, at one entry
//   per cycle, the F front candidates that leave the window (0 or 1 while window_size is
//   steady, up to 64 after it shrinks), and inserts the sample once no unaccepted result
//   holds the slot; the result is registered with that insert. A new sample is accepted
//   only after the previous one is inserted. Config every cycle.
// Reset: deque empty, counts zero, window_size 1, no result pending.
// ---------------------------------------------------------------------------
// Sliding window maximum
// Monotonic deque of candidates kept in a chain of cells; emits the window
// maximum once the window of the current array is full.
// ---------------------------------------------------------------------------
`include "sliding_window_maximum_assert.svh"

module sliding_window_maximum (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swm_pkg::WIN_W-1:0]        window_size,
  // samples
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] sample_value,
  input  logic                             start_of_array,
  input  logic                             end_of_array,
  // results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [swm_pkg::DATA_W-1:0] window_max,
  output logic                             last_window
);

  swm_pkg::state_t     state, state_next;
  swm_pkg::cell_ctl_t  ctl;
  swm_pkg::entry_t     front;

  logic [swm_pkg::WIN_W-1:0]         win;
  logic [swm_pkg::WIN_W-1:0]         win_eff;
  logic [swm_pkg::POS_W-1:0]         sample_position;
  logic [swm_pkg::CNT_W-1:0]         seen_count;
  logic [swm_pkg::CNT_W-1:0]         seen_next;
  logic [swm_pkg::POS_W-1:0]         front_age;
  logic                              front_expired;
  logic signed [swm_pkg::DATA_W-1:0] held_value;
  logic                              held_last;
  logic signed [swm_pkg::DATA_W-1:0] front_after;
  logic                              accept;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= swm_pkg::WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      win <= window_size;
    end
  end

  // Clamp window to 1..K_MAX
  always_comb begin
    priority if (win == '0) begin
      win_eff = swm_pkg::WIN_W'(1);
    end else if (win > swm_pkg::K_MAX_WIN) begin
      win_eff = swm_pkg::K_MAX_WIN;
    end else begin
      win_eff = win;
    end
  end

  // Front expiry and post-insert front value
  assign front_age     = sample_position - front.pos;
  assign front_expired = front.valid && (front_age >= win_eff);
  assign front_after   = (front.valid && (front.value > held_value)) ? front.value
                                                                      : held_value;
  assign seen_next     = (seen_count < swm_pkg::K_MAX_CNT) ? seen_count + 1'b1
                                                           : seen_count;
  assign accept        = in_valid && in_ready;

  // Control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and cell commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.value  = held_value;
    ctl.pos    = sample_position;
    in_ready   = 1'b0;
    unique case (state)
      swm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.clear  = start_of_array;
          state_next = swm_pkg::ST_RUN;
        end
      end
      swm_pkg::ST_RUN: begin
        if (front_expired) begin
          ctl.shift = 1'b1;
        end else if (!out_valid || out_ready) begin
          ctl.insert = 1'b1;
          state_next = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swm_pkg::ST_IDLE;
      end
    endcase
  end

  // Held sample
  always_ff @(posedge clk) begin
    if (accept) begin
      held_value <= sample_value;
      held_last  <= end_of_array;
    end
  end

  // Position and array counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      seen_count      <= '0;
    end else if (accept && start_of_array) begin
      sample_position <= '0;
      seen_count      <= '0;
    end else if (ctl.insert) begin
      sample_position <= sample_position + 1'b1;
      seen_count      <= seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.insert && (seen_next >= win_eff)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && (seen_next >= win_eff)) begin
      window_max  <= front_after;
      last_window <= held_last;
    end
  end

  // Candidate deque
  swm_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .front (front)
  );

  // Checks
  `SWM_ASSERT(a_front_after_insert, ctl.insert |=> front.valid, "deque empty after insert")
  `SWM_ASSERT(a_shift_needs_front, ctl.shift |-> front.valid, "shift with empty deque")
  `SWM_ASSERT(a_insert_slot_free, ctl.insert |-> (!out_valid || out_ready), "result overwritten")
  `SWM_ASSERT(a_seen_bounded, seen_count <= swm_pkg::K_MAX_CNT, "seen count overflow")

endmodule

### dv/sliding_window_maximum_checker.sv
// ---------------------------------------------------------------------------
// Sliding window maximum checker
// Watches the configuration, sample and result channels, keeps its own
// monotonic deque to predict each window maximum, and compares every result
// transaction with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module sliding_window_maximum_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [swm_pkg::WIN_W-1:0]         window_size,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] sample_value,
  input  logic                              start_of_array,
  input  logic                              end_of_array,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [swm_pkg::DATA_W-1:0] window_max,
  input  logic                              last_window,
  output int                                mismatches,
  output int                                outstanding
);

  // positions wrap well beyond any age a candidate can reach
  localparam int POS_MOD = 2048;

  typedef struct {
    logic signed [swm_pkg::DATA_W-1:0] value;
    int                                pos;
  } cand_t;

  typedef struct {
    logic signed [swm_pkg::DATA_W-1:0] win_max;
    logic                              last;
  } window_result_t;

  cand_t                     cand_q[$];
  window_result_t            pending_max_q[$];
  logic [swm_pkg::WIN_W-1:0] win_reg;
  int                        next_pos;
  int                        seen_count;

  // Advance the deque by one sample; queue the window maximum once full
  function automatic void predict_window_max(input logic signed [swm_pkg::DATA_W-1:0] v,
                                             input logic sof, input logic eof);
    int             w;
    cand_t          c;
    window_result_t r;
    w = int'(win_reg);
    if (w < 1) w = 1;
    if (w > swm_pkg::K_MAX) w = swm_pkg::K_MAX;
    if (sof) begin
      cand_q.delete();
      next_pos   = 0;
      seen_count = 0;
    end
    // front entries that fell out of the window
    while (cand_q.size() > 0 && ((next_pos - cand_q[0].pos + POS_MOD) % POS_MOD) >= w)
      cand_q.delete(0);
    // back entries dominated by the new sample (ties too)
    while (cand_q.size() > 0 && cand_q[$].value <= v)
      cand_q.delete(cand_q.size() - 1);
    if (cand_q.size() >= swm_pkg::K_MAX)
      cand_q.delete(0);
    c.value = v;
    c.pos   = next_pos;
    cand_q.insert(cand_q.size(), c);
    next_pos = (next_pos + 1) % POS_MOD;
    if (seen_count < swm_pkg::K_MAX) seen_count++;
    if (seen_count >= w) begin
      r.win_max = cand_q[0].value;
      r.last    = eof;
      pending_max_q.insert(pending_max_q.size(), r);
    end
  endfunction

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    window_result_t exp_r;
    if (rst) begin
      cand_q.delete();
      pending_max_q.delete();
      win_reg    = swm_pkg::WIN_W'(1);
      next_pos   = 0;
      seen_count = 0;
      mismatches = 0;
    end else begin
      // result transaction against oldest prediction
      if (out_valid && out_ready) begin
        if (pending_max_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got window_max %0d last_window %0b",
                   $time, window_max, last_window);
        end else begin
          exp_r = pending_max_q[0];
          pending_max_q.delete(0);
          if (window_max !== exp_r.win_max) begin
            mismatches++;
            $display("%0t: window_max expected %0d, got %0d",
                     $time, exp_r.win_max, window_max);
          end
          if (last_window !== exp_r.last) begin
            mismatches++;
            $display("%0t: last_window expected %0b, got %0b",
                     $time, exp_r.last, last_window);
          end
        end
      end
      if (in_valid && in_ready)
        predict_window_max(sample_value, start_of_array, end_of_array);
      // new window applies from the next sample
      if (cfg_valid && cfg_ready)
        win_reg = window_size;
    end
    outstanding <= pending_max_q.size();
  end

endmodule

### dv/tb_sliding_window_maximum.sv
// ---------------------------------------------------------------------------
// Sliding window maximum testbench
// Drives directed and random sample arrays through several window settings
// and idle/stall mixes; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_sliding_window_maximum;

  localparam int SETTLE_CYCLES = 80;       // covers the longest expiry latency
  localparam int PHASE_ITEMS   = 136;
  localparam int NUM_PHASES    = 12;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_FALLING,
    SHAPE_RISING,
    SHAPE_EXTREME
  } value_shape_t;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              cfg_valid      = 1'b0;
  logic                              cfg_ready;
  logic [swm_pkg::WIN_W-1:0]         window_size    = '0;
  logic                              in_valid       = 1'b0;
  logic                              in_ready;
  logic signed [swm_pkg::DATA_W-1:0] sample_value   = '0;
  logic                              start_of_array = 1'b0;
  logic                              end_of_array   = 1'b0;
  logic                              out_valid;
  logic                              out_ready      = 1'b0;
  logic signed [swm_pkg::DATA_W-1:0] window_max;
  logic                              last_window;

  int mismatches;
  int outstanding;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  int phase_window[NUM_PHASES] = '{0, 64, 127, 65, 2, 7, 33, 1, 16, 5, 64, 3};
  int sender_idle[4]           = '{0, 51, 0, 26};
  int receiver_stall[4]        = '{0, 0, 51, 26};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_maximum dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .start_of_array (start_of_array),
    .end_of_array   (end_of_array),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_max     (window_max),
    .last_window    (last_window)
  );

  sliding_window_maximum_checker u_max_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_size    (window_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .start_of_array (start_of_array),
    .end_of_array   (end_of_array),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_max     (window_max),
    .last_window    (last_window),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Result receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // One sample transaction, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [swm_pkg::DATA_W-1:0] v, input logic sof,
                             input logic eof);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample_value   <= v;
    start_of_array <= sof;
    end_of_array   <= eof;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until no result is owed and the pipeline has had time to drain
  task automatic settle_output();
    int quiet;
    quiet = 0;
    in_valid <= 1'b0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (outstanding == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_window(input int w);
    window_size <= swm_pkg::WIN_W'(w);
    cfg_valid   <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random arrays: mostly long enough to fill the window, some short,
  // with occasional missing or stray start/end flags
  task automatic run_phase(input int n_items, input int w_cfg);
    int                                sent;
    int                                w_eff;
    int                                len;
    int                                step;
    bit                                first;
    bit                                use_start;
    bit                                mark_end;
    logic                              sof;
    logic                              eof;
    logic signed [swm_pkg::DATA_W-1:0] base;
    logic signed [swm_pkg::DATA_W-1:0] v;
    value_shape_t                      shape;
    sent  = 0;
    first = 1'b1;
    w_eff = (w_cfg < 1) ? 1 : (w_cfg > swm_pkg::K_MAX) ? swm_pkg::K_MAX : w_cfg;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) len = $urandom_range(1, w_eff);
      else len = w_eff + $urandom_range(0, 40);
      if (len > n_items - sent) len = n_items - sent;
      // first array of a phase continues the previous one under the new window
      use_start = !first && ($urandom_range(9) != 0);
      mark_end  = ($urandom_range(9) != 0);
      shape     = value_shape_t'($urandom_range(4));
      base      = $urandom;
      step      = $urandom_range(1, 1000);
      for (int i = 0; i < len; i++) begin
        case (shape)
          SHAPE_RANDOM:  v = $urandom;
          SHAPE_NARROW:  v = $signed($urandom_range(0, 16)) - 8;
          SHAPE_FALLING: v = base - i * step;
          SHAPE_RISING:  v = base + i * step;
          default: begin
            case ($urandom_range(5))
              0:       v = 32'sh80000000;
              1:       v = 32'sh7FFFFFFF;
              2:       v = 32'sh80000001;
              3:       v = 32'sh7FFFFFFE;
              4:       v = -1;
              default: v = 0;
            endcase
          end
        endcase
        sof = (i == 0 && use_start) || ($urandom_range(99) < 3);
        eof = (i == len - 1 && mark_end) || ($urandom_range(99) < 3);
        send_sample(v, sof, eof);
        sent++;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset window of one: each sample is its own maximum
    send_sample(32'sh7FFFFFFF, 1'b1, 1'b0);
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(0, 1'b0, 1'b0);
    send_sample(-1, 1'b0, 1'b1);
    settle_output();

    write_window(4);
    // window fill, equal values, expiry of the front
    send_sample(5, 1'b1, 1'b0);
    send_sample(3, 1'b0, 1'b0);
    send_sample(3, 1'b0, 1'b0);
    send_sample(1, 1'b0, 1'b0);
    send_sample(2, 1'b0, 1'b0);
    send_sample(0, 1'b0, 1'b0);
    send_sample(-7, 1'b0, 1'b0);
    // most negative repeated, then most positive ending the array
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(32'sh7FFFFFFF, 1'b0, 1'b1);
    // no start after the end: same array continues
    send_sample(6, 1'b0, 1'b0);
    send_sample(6, 1'b0, 1'b0);
    // array ends before its window fills: no result
    send_sample(9, 1'b1, 1'b0);
    send_sample(8, 1'b0, 1'b1);
    // one-sample array
    send_sample(-2, 1'b1, 1'b1);
    settle_output();

    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct    = sender_idle[p % 4];
      receiver_stall_pct = receiver_stall[p % 4];
      write_window(phase_window[p]);
      run_phase(PHASE_ITEMS, phase_window[p]);
      settle_output();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_chain.sv
rtl/sliding_window_maximum.sv
dv/sliding_window_maximum_checker.sv
dv/tb_sliding_window_maximum.sv
